// ----- src/rad_pkg.sv -----
// ============================================================================
// rad_pkg: shared types and constants for the rectangle-add difference matrix
// Holds matrix geometry, word layouts and the controller/datapath interface.
// ============================================================================
`timescale 1ns / 1ps

package rad_pkg;

    // Matrix geometry (both dimensions are powers of two)
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DATA_W   = 32;

    // Field and register widths
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int CFG_AW   = 1;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_AW-1:0] REG_COLS_IN_USE = 1'd1;
    localparam logic [CNT_W-1:0]  CNT_RESET       = 7'd64;

    // Item operations
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_EMIT  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Input word
    typedef struct packed {
        op_t                      op;
        logic [IDX_W-1:0]         row_first;
        logic [IDX_W-1:0]         col_first;
        logic [IDX_W-1:0]         row_last;
        logic [IDX_W-1:0]         col_last;
        logic signed [DATA_W-1:0] amount;
    } item_t;

    // Result word
    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] cell_value;
        logic                     row_end;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic add_rd;
        logic add_wr;
        logic emit_rd;
        logic emit_calc;
        logic emit_done;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic corner_last;
        logic col_last;
        logic out_free;
    } sts_t;

endpackage

// ----- src/rad_ctrl.sv -----
// ============================================================================
// rad_ctrl: sequencer for the rectangle-add difference matrix
// Steps the clearing pass, the four corner read-modify-writes of an add and
// the per-cell read/compute cycles of a row emit.
// ============================================================================
`timescale 1ns / 1ps

module rad_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  rad_pkg::op_t  item_op,
    output logic          item_stall,
    output rad_pkg::cmd_t cmd,
    input  rad_pkg::sts_t sts
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_CLEAR     = 6'b000010,
        ST_ADD_RD    = 6'b000100,
        ST_ADD_WR    = 6'b001000,
        ST_EMIT_RD   = 6'b010000,
        ST_EMIT_CALC = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take a new word only when idle
    assign item_stall = (state_reg != ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    case (item_op)
                        rad_pkg::OP_ADD:   state_next = ST_ADD_RD;
                        rad_pkg::OP_EMIT:  state_next = ST_EMIT_RD;
                        rad_pkg::OP_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_RD:
            begin
                cmd.add_rd = 1'b1;
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = sts.corner_last ? ST_IDLE : ST_ADD_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_CALC;
            end
            ST_EMIT_CALC:
            begin
                // hold until the output register can take the cell
                if (sts.out_free)
                begin
                    cmd.emit_calc = 1'b1;
                    if (sts.col_last)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && sts.clr_last) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not return to idle");

    a_add_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WR && sts.corner_last) |=> (state_reg == ST_IDLE))
        else $error("add did not finish after the last corner");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_CALC && sts.out_free && sts.col_last)
        |=> (state_reg == ST_IDLE))
        else $error("emit did not finish after the last column");

endmodule

// ----- src/rad_datapath.sv -----
// ============================================================================
// rad_datapath: storage and arithmetic for the rectangle-add difference matrix
// Difference memory, column-sum memory with valid bits, row accumulator,
// configuration registers and the output register.
// ============================================================================
`timescale 1ns / 1ps

module rad_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rad_pkg::item_t               item,
    input  logic                         cfg_we,
    input  logic [rad_pkg::CFG_AW-1:0]   cfg_index,
    input  logic [rad_pkg::CNT_W-1:0]    cfg_data,
    input  rad_pkg::cmd_t                cmd,
    output rad_pkg::sts_t                sts,
    output logic                         result_valid,
    input  logic                         result_stall,
    output rad_pkg::result_t             result
);

    localparam int DW = rad_pkg::DATA_W;
    localparam int CW = rad_pkg::CNT_W;

    // Configuration and walk state
    logic [CW-1:0]                 rows_reg;
    logic [CW-1:0]                 cols_reg;
    logic [rad_pkg::ROW_AW-1:0]    next_row_reg;
    logic [rad_pkg::MAX_COLS-1:0]  cs_vld_reg;

    // Working registers
    rad_pkg::item_t                item_reg;
    logic [1:0]                    corner_reg;
    logic [rad_pkg::COL_AW-1:0]    col_reg;
    logic [rad_pkg::ADDR_W-1:0]    clr_addr_reg;
    logic [DW-1:0]                 acc_reg;
    logic                          out_valid_reg;
    rad_pkg::result_t              out_reg;

    // Memories and their read registers
    logic [DW-1:0]                 diff_mem [rad_pkg::DEPTH];
    logic [DW-1:0]                 colsum_mem [rad_pkg::MAX_COLS];
    logic [DW-1:0]                 rd_data_reg;
    logic [DW-1:0]                 cs_rd_reg;
    logic                          cs_vld_rd_reg;

    // Derived signals
    logic [CW-1:0]                 eff_rows;
    logic [CW-1:0]                 eff_cols;
    logic                          last_row;
    logic [CW-1:0]                 corner_row;
    logic [CW-1:0]                 corner_col;
    logic                          corner_ok;
    logic [DW-1:0]                 corner_amt;
    logic [rad_pkg::ADDR_W-1:0]    corner_addr;
    logic [rad_pkg::ADDR_W-1:0]    emit_addr;
    logic [rad_pkg::ADDR_W-1:0]    mem_addr;
    logic                          mem_we;
    logic                          mem_rd;
    logic [DW-1:0]                 mem_wdata;
    logic [DW-1:0]                 cs_new;
    logic [DW-1:0]                 acc_new;
    logic                          out_free;

    // Limit the counts to the matrix; a zero count is taken as one
    always_comb
    begin
        eff_rows = rows_reg;
        if (rows_reg == '0)
        begin
            eff_rows = CW'(1);
        end
        else if (rows_reg > CW'(rad_pkg::MAX_ROWS))
        begin
            eff_rows = CW'(rad_pkg::MAX_ROWS);
        end
        eff_cols = cols_reg;
        if (cols_reg == '0)
        begin
            eff_cols = CW'(1);
        end
        else if (cols_reg > CW'(rad_pkg::MAX_COLS))
        begin
            eff_cols = CW'(rad_pkg::MAX_COLS);
        end
    end

    assign last_row = (CW'(next_row_reg) + CW'(1)) >= eff_rows;

    // Corner select: first/first, first/last+1, last+1/first, last+1/last+1
    assign corner_row = corner_reg[1] ? (CW'(item_reg.row_last) + CW'(1))
                                      : CW'(item_reg.row_first);
    assign corner_col = corner_reg[0] ? (CW'(item_reg.col_last) + CW'(1))
                                      : CW'(item_reg.col_first);
    assign corner_ok  = (corner_row < CW'(rad_pkg::MAX_ROWS)) &&
                        (corner_col < CW'(rad_pkg::MAX_COLS));
    assign corner_amt = (corner_reg[1] ^ corner_reg[0]) ? (DW'(0) - item_reg.amount)
                                                        : item_reg.amount;
    assign corner_addr = {corner_row[rad_pkg::ROW_AW-1:0],
                          corner_col[rad_pkg::COL_AW-1:0]};
    assign emit_addr   = {next_row_reg, col_reg};

    // Difference memory port select
    assign mem_rd    = cmd.add_rd | cmd.emit_rd;
    assign mem_we    = cmd.clr_step | (cmd.add_wr & corner_ok);
    assign mem_wdata = cmd.clr_step ? '0 : (rd_data_reg + corner_amt);
    always_comb
    begin
        if (cmd.clr_step)
        begin
            mem_addr = clr_addr_reg;
        end
        else if (cmd.emit_rd)
        begin
            mem_addr = emit_addr;
        end
        else
        begin
            mem_addr = corner_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            diff_mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rd_data_reg <= diff_mem[mem_addr];
        end
    end

    // Column sums: read with the difference, write back the new sum
    assign cs_new  = (cs_vld_rd_reg ? cs_rd_reg : '0) + rd_data_reg;
    assign acc_new = acc_reg + cs_new;

    always_ff @(posedge clk)
    begin
        if (cmd.emit_calc)
        begin
            colsum_mem[col_reg] <= cs_new;
        end
        if (cmd.emit_rd)
        begin
            cs_rd_reg     <= colsum_mem[col_reg];
            cs_vld_rd_reg <= cs_vld_reg[col_reg];
        end
    end

    // Corner, column and clear counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg   <= '0;
            col_reg      <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                corner_reg <= '0;
                col_reg    <= '0;
            end
            else
            begin
                if (cmd.add_wr)
                begin
                    corner_reg <= corner_reg + 2'd1;
                end
                if (cmd.emit_calc)
                begin
                    col_reg <= col_reg + rad_pkg::COL_AW'(1);
                end
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + rad_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.load)
        begin
            acc_reg <= '0;
        end
        else if (cmd.emit_calc)
        begin
            acc_reg <= acc_new;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= rad_pkg::CNT_RESET;
            cols_reg <= rad_pkg::CNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rad_pkg::REG_ROWS_IN_USE: rows_reg <= cfg_data;
                rad_pkg::REG_COLS_IN_USE: cols_reg <= cfg_data;
                default:                  rows_reg <= rows_reg;
            endcase
        end
    end

    // Row pointer and column-sum valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_row_reg <= '0;
            cs_vld_reg   <= '0;
        end
        else if (cmd.clr_start || (cmd.emit_done && last_row))
        begin
            next_row_reg <= '0;
            cs_vld_reg   <= '0;
        end
        else
        begin
            if (cmd.emit_calc)
            begin
                cs_vld_reg[col_reg] <= 1'b1;
            end
            if (cmd.emit_done)
            begin
                next_row_reg <= next_row_reg + rad_pkg::ROW_AW'(1);
            end
        end
    end

    // Output register: free when empty or drained this cycle
    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_calc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_calc)
        begin
            out_reg.out_row    <= rad_pkg::IDX_W'(next_row_reg);
            out_reg.out_col    <= rad_pkg::IDX_W'(col_reg);
            out_reg.cell_value <= acc_new;
            out_reg.row_end    <= sts.col_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Status
    assign sts.clr_last    = (clr_addr_reg == rad_pkg::ADDR_W'(rad_pkg::DEPTH - 1));
    assign sts.corner_last = (corner_reg == 2'd3);
    assign sts.col_last    = ((CW'(col_reg) + CW'(1)) == eff_cols);
    assign sts.out_free    = out_free;

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_calc |-> out_free)
        else $error("cell computed while the output register is full");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |=> (next_row_reg == '0 ||
                           next_row_reg == $past(next_row_reg) + rad_pkg::ROW_AW'(1)))
        else $error("row pointer moved by other than one row");

    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_done && last_row) |=> (cs_vld_reg == '0 && next_row_reg == '0))
        else $error("column sums not reset after the last row");

endmodule

// ----- src/rect_add_difference_matrix.sv -----
// ============================================================================
// rect_add_difference_matrix: two-dimensional difference array
// Rectangle adds update four corners; emits rebuild one row of the prefix sum.
// ============================================================================
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+------------------------
//  item     | in        | item_valid / item_stall   | rad_pkg::item_t
//  result   | out       | result_valid / result_stall | rad_pkg::result_t
//  cfg      | in        | cfg_we (index cfg_index)  | cfg_data, 7 bits
//
//  Add: one read and one write per corner on the single-port difference
//  memory. Emit: a read and a compute step per cell; a stalled result holds
//  the walk. Clear: one memory entry zeroed per cycle. After reset a
//  clearing pass runs before the first word is taken; configuration writes
//  are taken throughout.
//  Column sums are zeroed at once through per-column valid bits.
//
`timescale 1ns / 1ps

module rect_add_difference_matrix (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  rad_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output rad_pkg::result_t           result,
    input  logic                       cfg_we,
    input  logic [rad_pkg::CFG_AW-1:0] cfg_index,
    input  logic [rad_pkg::CNT_W-1:0]  cfg_data
);

    rad_pkg::cmd_t cmd;
    rad_pkg::sts_t sts;

    // Sequencer
    rad_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.op),
        .item_stall (item_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Storage and arithmetic
    rad_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: self-checking bench for the rectangle-add difference matrix
// Drives add, emit, clear and unused words through the item channel, keeps a shadow
// difference matrix with running column sums, and checks every emitted cell.
// Runs a directed table first, then random phases over several count settings
// with random idling on both channels and one long result hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int           LIMIT       = 2_000_000;
    localparam int           SETTLE      = 4200;    // longer than one clear pass
    localparam int           HOLD_CYCLES = 600;
    localparam int           MAX_REPORTS = 50;
    localparam int           DIR_N       = 23;
    localparam int           N_PHASES    = 7;
    localparam rad_pkg::op_t OP_UNUSED   = rad_pkg::op_t'(2'd3);
    localparam int           ROW_CAP     = (rad_pkg::MAX_ROWS < 64) ? rad_pkg::MAX_ROWS : 64;

    typedef struct packed {
        rad_pkg::item_t word;
        logic           typed;
        logic [5:0]     row;
        logic [31:0]    fill;
    } dir_entry_t;

    typedef struct packed {
        logic [6:0]  rows;
        logic [6:0]  cols;
        logic [15:0] count;
        logic        quiet;
        logic        hold;
    } phase_t;

    // DUT ports, all known from time zero
    logic                       clk;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    rad_pkg::item_t             item         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    rad_pkg::result_t           result;
    logic                       cfg_we       = 1'b0;
    logic [rad_pkg::CFG_AW-1:0] cfg_index    = '0;
    logic [rad_pkg::CNT_W-1:0]  cfg_data     = '0;

    // Sideband travelling with each word: typed-in expectation for an emit
    logic                tag_typed    = 1'b0;
    logic [5:0]          tag_row      = '0;
    logic [31:0]         tag_fill     = '0;

    // Shadow state of the block
    logic [31:0]         diff_mem [rad_pkg::MAX_ROWS][rad_pkg::MAX_COLS];
    logic [31:0]         col_acc  [rad_pkg::MAX_COLS];
    logic [5:0]          walk_row;
    logic [6:0]          rows_reg = rad_pkg::CNT_RESET;
    logic [6:0]          cols_reg = rad_pkg::CNT_RESET;
    rad_pkg::result_t    cell_q [$];

    // Run control and tallies
    logic                idle_on  = 1'b1;
    logic                stall_on = 1'b1;
    logic                hold_req = 1'b0;
    int unsigned         cycle_count   = 0;
    int unsigned         errors        = 0;
    int unsigned         words_taken   = 0;
    int unsigned         clears_taken  = 0;
    int unsigned         cells_checked = 0;
    int unsigned         hold_total    = 0;
    int unsigned         settings      = 1;

    dir_entry_t          dir_tab [DIR_N];
    phase_t              phase_tab [N_PHASES];

    rect_add_difference_matrix u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("%0t: timeout after %0d cycles, %0d cells still expected",
                 $realtime, cycle_count, cell_q.size());
        $display("[rect_add_difference_matrix] ERROR");
        $finish;
    end

    function automatic int eff_count(input logic [6:0] n, input int cap);
        if (n == 0)
            return 1;
        if (n > cap)
            return cap;
        return n;
    endfunction

    // Drop corners that fall outside the matrix
    task automatic corner_add(input int r, input int c, input logic [31:0] v);
        if (r < rad_pkg::MAX_ROWS && c < rad_pkg::MAX_COLS)
            diff_mem[r][c] = diff_mem[r][c] + v;
    endtask

    task automatic clear_matrix();
        for (int r = 0; r < rad_pkg::MAX_ROWS; r++)
            for (int c = 0; c < rad_pkg::MAX_COLS; c++)
                diff_mem[r][c] = '0;
        for (int c = 0; c < rad_pkg::MAX_COLS; c++)
            col_acc[c] = '0;
        walk_row = '0;
    endtask

    // Advance the shadow matrix by one accepted word and queue its cells
    task automatic predict_cells(input rad_pkg::item_t w, input logic typed,
                                 input logic [5:0] trow, input logic [31:0] tfill);
        int               r1, c1, r2, c2;
        int               n_rows, n_cols;
        logic [31:0]      v;
        logic [31:0]      acc;
        rad_pkg::result_t exp_word;
        case (w.op)
            rad_pkg::OP_ADD:
            begin
                r1 = w.row_first;
                c1 = w.col_first;
                r2 = int'(w.row_last) + 1;
                c2 = int'(w.col_last) + 1;
                v  = w.amount;
                corner_add(r1, c1, v);
                corner_add(r1, c2, 32'd0 - v);
                corner_add(r2, c1, 32'd0 - v);
                corner_add(r2, c2, v);
            end
            rad_pkg::OP_EMIT:
            begin
                n_rows = eff_count(rows_reg, ROW_CAP);
                n_cols = eff_count(cols_reg, rad_pkg::MAX_COLS);
                acc    = '0;
                for (int j = 0; j < n_cols; j++)
                begin
                    col_acc[j]          = col_acc[j] + diff_mem[walk_row][j];
                    acc                 = acc + col_acc[j];
                    exp_word.out_row    = typed ? trow : walk_row;
                    exp_word.out_col    = 6'(j);
                    exp_word.cell_value = typed ? tfill : acc;
                    exp_word.row_end    = (j == n_cols - 1);
                    cell_q.push_back(exp_word);
                end
                // wrap the walk after the last row in use
                if (int'(walk_row) + 1 >= n_rows)
                begin
                    walk_row = '0;
                    for (int c = 0; c < rad_pkg::MAX_COLS; c++)
                        col_acc[c] = '0;
                end
                else
                    walk_row = walk_row + 1;
            end
            rad_pkg::OP_CLEAR:
            begin
                clear_matrix();
                clears_taken++;
            end
            default: ;
        endcase
    endtask

    task automatic report_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $realtime, what, want, got);
    endtask

    // Compare one emitted cell with the oldest expectation
    task automatic check_cell(input rad_pkg::result_t got);
        rad_pkg::result_t want;
        cells_checked++;
        if (cell_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected cell, expected none, actual %p", $realtime, got);
        end
        else
        begin
            want = cell_q.pop_front();
            if (got.out_row !== want.out_row)
                report_field("out_row", want.out_row, got.out_row);
            if (got.out_col !== want.out_col)
                report_field("out_col", want.out_col, got.out_col);
            if (got.cell_value !== want.cell_value)
                report_field("cell_value", want.cell_value, got.cell_value);
            if (got.row_end !== want.row_end)
                report_field("row_end", want.row_end, got.row_end);
        end
    endtask

    // Monitor both channels: predict first, then check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                predict_cells(item, tag_typed, tag_row, tag_fill);
                words_taken++;
            end
            if (result_valid && !result_stall)
                check_cell(result);
        end
    end

    // Result side: random stall, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_total += HOLD_CYCLES;
                hold_req = 1'b0;
            end
            result_stall <= stall_on && ($urandom_range(99) < 34);
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic push_word(input rad_pkg::item_t w, input logic typed,
                             input logic [5:0] trow, input logic [31:0] tfill);
        while (idle_on && $urandom_range(99) < 34)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        tag_typed  <= typed;
        tag_row    <= trow;
        tag_fill   <= tfill;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Wait out every expected cell, then a full clear pass
    task automatic drain_and_settle();
        while (cell_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_counts(input logic [6:0] rows, input logic [6:0] cols);
        cfg_we    <= 1'b1;
        cfg_index <= rad_pkg::REG_ROWS_IN_USE;
        cfg_data  <= rows;
        @(posedge clk);
        rows_reg   = rows;
        cfg_index <= rad_pkg::REG_COLS_IN_USE;
        cfg_data  <= cols;
        @(posedge clk);
        cols_reg   = cols;
        cfg_we    <= 1'b0;
        settings++;
    endtask

    function automatic rad_pkg::item_t mk(input rad_pkg::op_t op, input int r1,
                                          input int c1, input int r2, input int c2,
                                          input logic [31:0] amt);
        rad_pkg::item_t w;
        w.op        = op;
        w.row_first = 6'(r1);
        w.col_first = 6'(c1);
        w.row_last  = 6'(r2);
        w.col_last  = 6'(c2);
        w.amount    = amt;
        return w;
    endfunction

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    // Mostly adds and emits with random content, some clears and unused ops
    function automatic rad_pkg::item_t rand_word(input int lim_r, input int lim_c);
        rad_pkg::item_t w;
        int             pick, a, b;
        w           = mk(rad_pkg::OP_ADD, $urandom_range(63), $urandom_range(63),
                         $urandom_range(63), $urandom_range(63), $urandom);
        pick        = $urandom_range(99);
        if (pick < 45)
        begin
            case ($urandom_range(3))
                0, 1:
                begin
                    // well-formed rectangle inside the area in use
                    a = $urandom_range(lim_r - 1);
                    b = $urandom_range(lim_r - 1);
                    w.row_first = 6'((a < b) ? a : b);
                    w.row_last  = 6'((a < b) ? b : a);
                    a = $urandom_range(lim_c - 1);
                    b = $urandom_range(lim_c - 1);
                    w.col_first = 6'((a < b) ? a : b);
                    w.col_last  = 6'((a < b) ? b : a);
                end
                2: ;
                default:
                begin
                    // push corners onto the matrix edge
                    w.row_last = 6'd63;
                    w.col_last = 6'd63;
                    if ($urandom_range(1))
                        w.row_first = 6'd63;
                end
            endcase
            w.amount = rand_amount();
        end
        else if (pick < 88)
            w.op = rad_pkg::OP_EMIT;
        else if (pick < 91)
            w.op = rad_pkg::OP_CLEAR;
        else
            w.op = OP_UNUSED;
        return w;
    endfunction

    // Main sequence
    initial
    begin
        rad_pkg::item_t w;
        int             n;

        dir_tab = '{
            // whole-matrix add shows up as one constant row
            '{mk(rad_pkg::OP_ADD,   0,  0, 63, 63, 32'h7FFF_FFFF), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b1, 6'd0, 32'h7FFF_FFFF},
            '{mk(rad_pkg::OP_ADD,   1,  0, 63, 63, 32'h1),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b1, 6'd1, 32'h8000_0000},
            '{mk(rad_pkg::OP_ADD,   2,  0, 63, 63, 32'h8000_0000), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b1, 6'd2, 32'h0},
            // reversed corners, dropped corners on the edges
            '{mk(rad_pkg::OP_ADD,   5,  9,  3,  4, 32'h7),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,   3, 63,  3, 63, 32'h8000_0000), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,  63, 63, 63, 63, 32'hFFFF_FFFF), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,  63,  0, 63, 62, 32'h1234_5678), 1'b0, 6'd0, 32'h0},
            '{mk(OP_UNUSED,        63, 63, 63, 63, 32'hFFFF_FFFF), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT, 63, 63, 63, 63, 32'hFFFF_FFFF), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            // clear restarts the walk at row zero
            '{mk(rad_pkg::OP_CLEAR, 0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b1, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,   0,  0,  0,  0, 32'hFFFF_FFFB), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,   1,  2,  1,  2, 32'h9),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,   0,  0, 63,  0, 32'h7FFF_FFFF), 1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_EMIT,  0,  0,  0,  0, 32'h0),         1'b0, 6'd0, 32'h0},
            '{mk(rad_pkg::OP_ADD,  10, 10, 20, 20, 32'hFFFF_FFFF), 1'b0, 6'd0, 32'h0}
        };

        // rows, cols, words, quiet, hold; the walk is left mid-matrix between phases
        phase_tab = '{
            '{7'd1,   7'd1,   16'd40, 1'b0, 1'b0},
            '{7'd0,   7'd0,   16'd20, 1'b0, 1'b0},
            '{7'd3,   7'd5,   16'd60, 1'b1, 1'b0},
            '{7'd127, 7'd127, 16'd40, 1'b0, 1'b1},
            '{7'd64,  7'd64,  16'd30, 1'b0, 1'b0},
            '{7'd2,   7'd64,  16'd50, 1'b0, 1'b0},
            '{7'd7,   7'd33,  16'd50, 1'b0, 1'b0}
        };

        clear_matrix();

        // Hold reset, then release
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table at reset counts
        for (int i = 0; i < DIR_N; i++)
            push_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].row, dir_tab[i].fill);
        item_valid <= 1'b0;
        drain_and_settle();

        // Random phases, counts changed only while the block is idle
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_counts(phase_tab[p].rows, phase_tab[p].cols);
            idle_on  = !phase_tab[p].quiet;
            stall_on = !phase_tab[p].quiet;
            if (phase_tab[p].hold)
                hold_req = 1'b1;
            n = 0;
            while (n < phase_tab[p].count)
            begin
                w = rand_word(eff_count(rows_reg, ROW_CAP),
                              eff_count(cols_reg, rad_pkg::MAX_COLS));
                n++;
                push_word(w, 1'b0, 6'd0, 32'h0);
            end
            item_valid <= 1'b0;
            drain_and_settle();
        end

        $display("Covered %0d words (%0d clears) and %0d checked cells over %0d count settings,",
                 words_taken, clears_taken, cells_checked, settings);
        $display("with random idling on both channels and a %0d-cycle result hold-off.",
                 hold_total);
        if (errors == 0 && cell_q.size() == 0)
            $display("[rect_add_difference_matrix] OK");
        else
            $display("[rect_add_difference_matrix] ERROR");
        $finish;
    end

endmodule
